### design/tsce_pkg.sv
// Shared types and constants for the terminal scrollback character engine.
// No dependencies.
package tsce_pkg;

  // Operation codes of an input transfer
  typedef enum logic [2:0] {
    OP_PUT       = 3'd0,
    OP_SCROLL_UP = 3'd1,
    OP_SCROLL_DN = 3'd2,
    OP_READ      = 3'd3,
    OP_CLR_DIRTY = 3'd4
  } opcode_t;

  // Configuration register indexes (byte address bits 3:2)
  localparam logic [1:0] REG_NUM_COLS   = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS   = 2'd1;
  localparam logic [1:0] REG_RING_LINES = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  // Tab stops every eight columns
  localparam logic [8:0] TAB_STEP = 9'd8;
  localparam logic [8:0] TAB_MASK = ~9'd7;

endpackage

### design/terminal_scrollback_char_engine.sv
// Terminal scrollback character engine: sequencer, ring bookkeeping and text store.
// Depends on tsce_pkg.
//
// One command is accepted when start is high and busy is low; busy then stays high until
// the command is done, and its result appears for exactly one cycle with out_valid high.
// The result cannot be held off. A read, scroll, dirty clear, carriage return, backspace
// or dropped byte passes an execute step, a text store read and a read-data step (one text
// store access per step); a plain character adds a write step. A tab blanks one cell per
// cycle up to the tab stop (up to 8 cells). A newline, and any wrap, claims a ring line and
// blanks its num_cols cells one cell a cycle. After reset, after any configuration write
// and on opcodes 5..7 the text store is swept to spaces, all MAX_RING_LINES * MAX_COLUMNS
// cells (both rounded up to powers of two; 32768 at the defaults), during which busy is
// high; configuration writes are taken at any time.
module terminal_scrollback_char_engine #(
  parameter int MAX_COLUMNS     = 128,
  parameter int MAX_SCREEN_ROWS = 32,
  parameter int MAX_RING_LINES  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_row,
  input  logic [6:0]  in_col,
  // result channel
  output logic        out_valid,
  output logic [7:0]  out_cell_char,
  output logic [31:0] out_dirty_rows,
  output logic [7:0]  out_column_now,
  output logic [4:0]  out_row_now,
  output logic [8:0]  out_view_offset,
  output logic [8:0]  out_lines_in_use,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsce_pkg::*;

  localparam int CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RAW = (MAX_RING_LINES > 1) ? $clog2(MAX_RING_LINES) : 1;
  localparam int AW  = RAW + CAW;
  localparam int DW  = MAX_SCREEN_ROWS;

  localparam logic [7:0] NC_RST = 8'((80 > MAX_COLUMNS) ? MAX_COLUMNS : 80);
  localparam logic [5:0] NR_RST = 6'((25 > MAX_SCREEN_ROWS) ? MAX_SCREEN_ROWS : 25);
  localparam logic [8:0] RL_RST = 9'((256 > MAX_RING_LINES) ? MAX_RING_LINES : 256);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_PUT, ST_TAB, ST_NL, ST_NLCLR, ST_READ, ST_RDWAIT
  } state_t;

  // sequencer and terminal state
  state_t           state_r, state_nxt, ret_r, ret_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             from_op_r, from_op_nxt;
  logic [7:0]       cx_r, cx_nxt;
  logic [5:0]       cy_r, cy_nxt;
  logic [8:0]       rs_r, rs_nxt;
  logic [8:0]       lh_r, lh_nxt;
  logic [8:0]       vb_r, vb_nxt;
  logic [DW-1:0]    dirty_r, dirty_nxt;
  logic [8:0]       stop_r, stop_nxt;
  logic [8:0]       clr_row_r, clr_row_nxt;
  logic [7:0]       ncol_r, ncol_nxt;
  logic             blank_r, blank_nxt;
  // latched command
  logic [2:0]       op_r;
  logic [7:0]       ch_r;
  logic [4:0]       row_r;
  logic [6:0]       col_r;
  // configuration
  logic [7:0]       num_cols_r, num_cols_nxt;
  logic [5:0]       num_rows_r, num_rows_nxt;
  logic [8:0]       ring_lines_r, ring_lines_nxt;
  // result registers
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_cell_r, out_cell_nxt;

  // text store
  logic [7:0]       mem [2**AW];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_q;

  // derived sizes
  logic [5:0]       ur;
  logic [8:0]       uring;
  logic [7:0]       uc;
  logic [DW-1:0]    all_mask;
  logic [8:0]       live_row, rd_row;
  logic             cfg_wr;

  function automatic logic [DW-1:0] row_bit(input logic [5:0] v);
    logic [DW-1:0] m;
    for (int i = 0; i < DW; i++) m[i] = ({26'b0, v} == 32'(i));
    return m;
  endfunction

  function automatic logic [8:0] wrap_idx(input logic [9:0] s, input logic [8:0] ring);
    logic [9:0] t;
    t = (s >= {1'b0, ring}) ? (s - {1'b0, ring}) : s;
    return t[8:0];
  endfunction

  assign uc    = num_cols_r;
  assign ur    = (32'(num_rows_r) > MAX_RING_LINES) ? 6'(MAX_RING_LINES) : num_rows_r;
  assign uring = (ring_lines_r < {3'b0, ur}) ? {3'b0, ur} : ring_lines_r;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    for (int i = 0; i < DW; i++) all_mask[i] = (32'(i) < {26'b0, ur});
  end

  // ring line of the cursor row on the live screen
  always_comb begin
    logic [8:0] live;
    live = (lh_r < {3'b0, ur}) ? lh_r : {3'b0, ur};
    live_row = wrap_idx({1'b0, rs_r} + {1'b0, lh_r - live} + {4'b0, cy_r}, uring);
  end

  // ring line of the requested visible row
  always_comb begin
    logic [8:0] room, top;
    room = lh_r - {3'b0, ur};
    top  = 9'd0;
    if (lh_r > {3'b0, ur}) top = (vb_r < room) ? (room - vb_r) : 9'd0;
    rd_row = wrap_idx({1'b0, rs_r} + {1'b0, top} + {5'b0, row_r}, uring);
  end

  // sequencer
  always_comb begin
    logic [DW-1:0] d;
    logic [8:0]    lim;
    logic [9:0]    t;
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    from_op_nxt   = from_op_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rs_nxt        = rs_r;
    lh_nxt        = lh_r;
    vb_nxt        = vb_r;
    dirty_nxt     = dirty_r;
    stop_nxt      = stop_r;
    clr_row_nxt   = clr_row_r;
    ncol_nxt      = ncol_r;
    blank_nxt     = blank_r;
    num_cols_nxt  = num_cols_r;
    num_rows_nxt  = num_rows_r;
    ring_lines_nxt = ring_lines_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = out_cell_r;
    mem_we        = 1'b0;
    mem_waddr     = {RAW'(live_row), CAW'(cx_r)};
    mem_wdata     = CH_SPACE;
    mem_raddr     = {RAW'(rd_row), CAW'(col_r)};
    d             = dirty_r;
    lim           = 9'd0;
    t             = 10'd0;

    case (state_r)
      // sweep the whole store to spaces
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (&cnt_r) state_nxt = from_op_r ? ST_READ : ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_READ;
        case (op_r)
          OP_PUT: begin
            if (vb_r != 9'd0) begin
              vb_nxt = 9'd0;
              d = d | all_mask;
            end
            if (ch_r == CH_LF) begin
              d = d | row_bit(cy_r);
              cx_nxt = 8'd0;
              ret_nxt = ST_READ;
              state_nxt = ST_NL;
            end else if (ch_r == CH_CR) begin
              d = d | row_bit(cy_r);
              cx_nxt = 8'd0;
            end else if (ch_r == CH_BS) begin
              if (cx_r != 8'd0) begin
                cx_nxt = cx_r - 8'd1;
                mem_we = 1'b1;
                mem_waddr = {RAW'(live_row), CAW'(cx_r - 8'd1)};
                d = d | row_bit(cy_r);
              end
            end else if (ch_r == CH_TAB) begin
              stop_nxt = ({1'b0, cx_r} + TAB_STEP) & TAB_MASK;
              state_nxt = ST_TAB;
            end else if (ch_r >= CH_FIRST && ch_r <= CH_LAST) begin
              if (cx_r >= uc) begin
                cx_nxt = 8'd0;
                ret_nxt = ST_PUT;
                state_nxt = ST_NL;
              end else begin
                state_nxt = ST_PUT;
              end
            end
            dirty_nxt = d;
          end
          OP_SCROLL_UP: begin
            lim = (lh_r > {3'b0, ur}) ? (lh_r - {3'b0, ur}) : 9'd0;
            t = {1'b0, vb_r} + {4'b0, ur};
            vb_nxt = (t > {1'b0, lim}) ? lim : t[8:0];
            dirty_nxt = dirty_r | all_mask;
          end
          OP_SCROLL_DN: begin
            vb_nxt = (vb_r > {3'b0, ur}) ? (vb_r - {3'b0, ur}) : 9'd0;
            dirty_nxt = dirty_r | all_mask;
          end
          OP_READ: begin
          end
          OP_CLR_DIRTY: begin
            if ({1'b0, row_r} < ur) dirty_nxt = dirty_r & ~row_bit({1'b0, row_r});
          end
          default: begin
            state_nxt   = ST_CLEAR;
            from_op_nxt = 1'b1;
            cnt_nxt     = '0;
            rs_nxt      = 9'd0;
            lh_nxt      = 9'd1;
            cx_nxt      = 8'd0;
            cy_nxt      = 6'd0;
            vb_nxt      = 9'd0;
            dirty_nxt   = '0;
          end
        endcase
      end
      // store a printable character at the cursor
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = ch_r;
        dirty_nxt = dirty_r | row_bit(cy_r);
        cx_nxt    = cx_r + 8'd1;
        state_nxt = ST_READ;
      end
      // blank one cell per cycle up to the tab stop
      ST_TAB: begin
        if ({1'b0, cx_r} < stop_r && cx_r < uc) begin
          mem_we    = 1'b1;
          dirty_nxt = dirty_r | row_bit(cy_r);
          cx_nxt    = cx_r + 8'd1;
        end else if (cx_r >= uc) begin
          cx_nxt    = 8'd0;
          ret_nxt   = ST_READ;
          state_nxt = ST_NL;
        end else begin
          state_nxt = ST_READ;
        end
      end
      // claim a ring line: append, or recycle the oldest when full
      ST_NL: begin
        if (lh_r < uring) begin
          clr_row_nxt = wrap_idx({1'b0, rs_r} + {1'b0, lh_r}, uring);
          lh_nxt = lh_r + 9'd1;
        end else begin
          clr_row_nxt = rs_r;
          rs_nxt = wrap_idx({1'b0, rs_r} + 10'd1, uring);
        end
        ncol_nxt  = 8'd0;
        state_nxt = ST_NLCLR;
      end
      // blank the new line, then advance the cursor row unless it is the last screen row
      ST_NLCLR: begin
        mem_we    = 1'b1;
        mem_waddr = {RAW'(clr_row_r), CAW'(ncol_r)};
        ncol_nxt  = ncol_r + 8'd1;
        if ({1'b0, ncol_r} + 9'd1 >= {1'b0, uc}) begin
          if ({1'b0, cy_r} + 7'd1 < {1'b0, ur}) begin
            cy_nxt    = cy_r + 6'd1;
            dirty_nxt = dirty_r | row_bit(cy_r + 6'd1);
          end else begin
            dirty_nxt = dirty_r | all_mask;
          end
          state_nxt = ret_r;
        end
      end
      // fetch the requested visible cell
      ST_READ: begin
        blank_nxt = ({1'b0, row_r} >= ur) || ({4'b0, row_r} >= lh_r) ||
                    ({1'b0, col_r} >= uc) || (32'(col_r) >= MAX_COLUMNS);
        state_nxt = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        out_cell_nxt  = blank_r ? CH_SPACE : mem_q;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write: saturate, latch, re-initialize
    if (cfg_wr && (paddr[3:2] == REG_NUM_COLS || paddr[3:2] == REG_NUM_ROWS ||
                   paddr[3:2] == REG_RING_LINES)) begin
      case (paddr[3:2])
        REG_NUM_COLS: begin
          num_cols_nxt = (pwdata[7:0] == 8'd0) ? 8'd1 :
                         (32'(pwdata[7:0]) > MAX_COLUMNS) ? 8'(MAX_COLUMNS) : pwdata[7:0];
        end
        REG_NUM_ROWS: begin
          num_rows_nxt = (pwdata[5:0] == 6'd0) ? 6'd1 :
                         (32'(pwdata[5:0]) > MAX_SCREEN_ROWS) ? 6'(MAX_SCREEN_ROWS) :
                         pwdata[5:0];
        end
        REG_RING_LINES: begin
          ring_lines_nxt = (pwdata[8:0] == 9'd0) ? 9'd1 :
                           (32'(pwdata[8:0]) > MAX_RING_LINES) ? 9'(MAX_RING_LINES) :
                           pwdata[8:0];
        end
        default: begin
        end
      endcase
      state_nxt   = ST_CLEAR;
      from_op_nxt = 1'b0;
      cnt_nxt     = '0;
      rs_nxt      = 9'd0;
      lh_nxt      = 9'd1;
      cx_nxt      = 8'd0;
      cy_nxt      = 6'd0;
      vb_nxt      = 9'd0;
      dirty_nxt   = '0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      ret_r        <= ST_READ;
      cnt_r        <= '0;
      from_op_r    <= 1'b0;
      cx_r         <= 8'd0;
      cy_r         <= 6'd0;
      rs_r         <= 9'd0;
      lh_r         <= 9'd1;
      vb_r         <= 9'd0;
      dirty_r      <= '0;
      num_cols_r   <= NC_RST;
      num_rows_r   <= NR_RST;
      ring_lines_r <= RL_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      cnt_r        <= cnt_nxt;
      from_op_r    <= from_op_nxt;
      cx_r         <= cx_nxt;
      cy_r         <= cy_nxt;
      rs_r         <= rs_nxt;
      lh_r         <= lh_nxt;
      vb_r         <= vb_nxt;
      dirty_r      <= dirty_nxt;
      num_cols_r   <= num_cols_nxt;
      num_rows_r   <= num_rows_nxt;
      ring_lines_r <= ring_lines_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stop_r     <= stop_nxt;
    clr_row_r  <= clr_row_nxt;
    ncol_r     <= ncol_nxt;
    blank_r    <= blank_nxt;
    out_cell_r <= out_cell_nxt;
    if (state_r == ST_IDLE && start) begin
      op_r  <= in_opcode;
      ch_r  <= in_char_code;
      row_r <= in_row;
      col_r <= in_col;
    end
  end

  // text store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_NUM_COLS:   prdata = {24'b0, num_cols_r};
      REG_NUM_ROWS:   prdata = {26'b0, num_rows_r};
      REG_RING_LINES: prdata = {23'b0, ring_lines_r};
      default:        prdata = 32'b0;
    endcase
  end

  assign pready           = 1'b1;
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_cell_char    = out_cell_r;
  assign out_dirty_rows   = 32'(dirty_r);
  assign out_column_now   = cx_r;
  assign out_row_now      = 5'(cy_r);
  assign out_view_offset  = vb_r;
  assign out_lines_in_use = lh_r;

  // a result only follows the read-data step
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_RDWAIT)
    else $error("result strobe without a completed cell read");

  // an accepted command raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_wr) |=> busy)
    else $error("busy not raised after accept");

  // ring fill stays within the ring
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (lh_r >= 9'd1 && lh_r <= uring && rs_r < uring))
    else $error("ring bookkeeping out of range");

  // the cursor never passes the pending-wrap column
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cx_r <= uc && {1'b0, cy_r} < {1'b0, ur}))
    else $error("cursor out of range");

endmodule

### tb/sv/tb_top.sv
// Testbench for the terminal scrollback character engine: command, result and APB ports.
// Depends on tsce_pkg and terminal_scrollback_char_engine; predicts every result itself.
`timescale 1ns / 100ps

module tb_top;
  import tsce_pkg::*;

  localparam int COLS_MAX     = 128;
  localparam int ROWS_MAX     = 32;
  localparam int RING_MAX     = 256;
  localparam int STALL_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 300;
  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam logic [2:0] OP_REINIT_5 = 3'd5;
  localparam logic [2:0] OP_REINIT_6 = 3'd6;
  localparam logic [2:0] OP_REINIT_7 = 3'd7;

  typedef struct {
    logic [7:0]  char_val;
    logic [31:0] dirty;
    logic [7:0]  col;
    logic [4:0]  row;
    logic [8:0]  view;
    logic [8:0]  lines;
  } term_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode = '0;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_row = '0;
  logic [6:0]  in_col = '0;
  logic        out_valid;
  logic [7:0]  out_cell_char;
  logic [31:0] out_dirty_rows;
  logic [7:0]  out_column_now;
  logic [4:0]  out_row_now;
  logic [8:0]  out_view_offset;
  logic [8:0]  out_lines_in_use;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  terminal_scrollback_char_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_char_code(in_char_code), .in_row(in_row), .in_col(in_col),
    .out_valid(out_valid), .out_cell_char(out_cell_char), .out_dirty_rows(out_dirty_rows),
    .out_column_now(out_column_now), .out_row_now(out_row_now),
    .out_view_offset(out_view_offset), .out_lines_in_use(out_lines_in_use),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predicted terminal state
  logic [7:0]   screen_text [0:RING_MAX*COLS_MAX-1];
  int unsigned  reg_cols = 80, reg_rows = 25, reg_ring = 256;
  int unsigned  act_cols, act_rows, act_ring;
  int unsigned  ring_head, held_lines, cur_x, cur_y, scroll_back;
  logic [31:0]  redraw_mask;
  term_status_t pending_status [$];
  int           err_count = 0;
  int           stall_cycles = 0;
  bit           gaps_off = 1'b0;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic term_init();
    act_cols = reg_cols;
    act_rows = reg_rows;
    act_ring = (reg_ring < act_rows) ? act_rows : reg_ring;
    foreach (screen_text[i]) screen_text[i] = CH_SPACE;
    ring_head = 0;
    held_lines = 1;
    cur_x = 0;
    cur_y = 0;
    scroll_back = 0;
    redraw_mask = '0;
  endtask

  task automatic mark_screen();
    for (int r = 0; r < act_rows; r++) redraw_mask[r] = 1'b1;
  endtask

  // Open a fresh ring line, recycling the oldest when full, then move the cursor down unless on the last row
  task automatic line_feed();
    int unsigned idx;
    if (held_lines < act_ring) begin
      idx = (ring_head + held_lines) % act_ring;
      held_lines++;
    end else begin
      idx = ring_head;
      ring_head = (ring_head + 1) % act_ring;
    end
    for (int c = 0; c < COLS_MAX; c++) screen_text[idx*COLS_MAX + c] = CH_SPACE;
    if (cur_y + 1 < act_rows) begin
      cur_y++;
      redraw_mask[cur_y] = 1'b1;
    end else begin
      mark_screen();
    end
  endtask

  task automatic write_live(int unsigned x, logic [7:0] ch);
    int unsigned live, idx;
    live = (held_lines < act_rows) ? held_lines : act_rows;
    idx = (ring_head + (held_lines - live) + cur_y) % act_ring;
    if (x < COLS_MAX) screen_text[idx*COLS_MAX + x] = ch;
  endtask

  task automatic put_char(logic [7:0] ch);
    int unsigned tab_stop;
    if (scroll_back != 0) begin
      scroll_back = 0;
      mark_screen();
    end
    case (ch)
      CH_LF: begin
        redraw_mask[cur_y] = 1'b1;
        cur_x = 0;
        line_feed();
      end
      CH_CR: begin
        redraw_mask[cur_y] = 1'b1;
        cur_x = 0;
      end
      CH_BS: begin
        if (cur_x > 0) begin
          cur_x--;
          write_live(cur_x, CH_SPACE);
          redraw_mask[cur_y] = 1'b1;
        end
      end
      CH_TAB: begin
        tab_stop = (cur_x + TAB_STEP) & TAB_MASK;
        while (cur_x < tab_stop && cur_x < act_cols) begin
          write_live(cur_x, CH_SPACE);
          redraw_mask[cur_y] = 1'b1;
          cur_x++;
        end
        if (cur_x >= act_cols) begin
          cur_x = 0;
          line_feed();
        end
      end
      default: begin
        if (ch >= CH_FIRST && ch <= CH_LAST) begin
          // take the pending wrap before printing
          if (cur_x >= act_cols) begin
            cur_x = 0;
            line_feed();
          end
          write_live(cur_x, ch);
          redraw_mask[cur_y] = 1'b1;
          cur_x++;
        end
      end
    endcase
  endtask

  function automatic logic [7:0] visible_cell(int unsigned r, int unsigned c);
    int unsigned top, room;
    top = 0;
    if (r >= act_rows || r >= held_lines || c >= act_cols) return CH_SPACE;
    if (held_lines > act_rows) begin
      room = held_lines - act_rows;
      top = (scroll_back < room) ? room - scroll_back : 0;
    end
    return screen_text[((ring_head + top + r) % act_ring)*COLS_MAX + c];
  endfunction

  // Advance the predicted state by one command and queue its status
  task automatic predict_command(logic [2:0] op, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
    int unsigned lim;
    term_status_t st;
    case (op)
      OP_PUT: put_char(ch);
      OP_SCROLL_UP: begin
        lim = (held_lines > act_rows) ? held_lines - act_rows : 0;
        scroll_back += act_rows;
        if (scroll_back > lim) scroll_back = lim;
        mark_screen();
      end
      OP_SCROLL_DN: begin
        scroll_back = (scroll_back > act_rows) ? scroll_back - act_rows : 0;
        mark_screen();
      end
      OP_READ: ;
      OP_CLR_DIRTY: if (r < act_rows) redraw_mask[r] = 1'b0;
      default: term_init();
    endcase
    st.char_val = visible_cell(r, c);
    st.dirty    = redraw_mask;
    st.col      = cur_x[7:0];
    st.row      = cur_y[4:0];
    st.view     = scroll_back[8:0];
    st.lines    = held_lines[8:0];
    pending_status.push_back(st);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: MISMATCH %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Compare each result transfer against the oldest prediction
  always @(negedge clk) begin
    term_status_t st;
    if (rst_n && out_valid) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        st = pending_status.pop_front();
        if (out_cell_char !== st.char_val)
          report_mismatch("cell_char", out_cell_char, st.char_val);
        if (out_dirty_rows !== st.dirty) report_mismatch("dirty_rows", out_dirty_rows, st.dirty);
        if (out_column_now !== st.col) report_mismatch("column_now", out_column_now, st.col);
        if (out_row_now !== st.row) report_mismatch("row_now", out_row_now, st.row);
        if (out_view_offset !== st.view)
          report_mismatch("view_offset", out_view_offset, st.view);
        if (out_lines_in_use !== st.lines)
          report_mismatch("lines_in_use", out_lines_in_use, st.lines);
      end
    end
  end

  // Watchdog: count cycles with no transfer on any port
  always @(negedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable) || !rst_n) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one command; returns at the edge that accepted it
  task automatic send_cmd(logic [2:0] op, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
    int gap;
    gap = (!gaps_off && $urandom_range(99) < 32) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    in_row       <= r;
    in_col       <= c;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_command(op, ch, r, c);
  endtask

  // Drop start and wait until every predicted result has arrived
  task automatic drain_results();
    start <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NUM_COLS:   reg_cols = clamp_reg(value & 32'hFF, COLS_MAX);
      REG_NUM_ROWS:   reg_rows = clamp_reg(value & 32'h3F, ROWS_MAX);
      REG_RING_LINES: reg_ring = clamp_reg(value & 32'h1FF, RING_MAX);
      default: ;
    endcase
    if (idx != REG_SPARE) term_init();
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned cols, int unsigned rows, int unsigned ring);
    drain_results();
    write_reg(REG_NUM_COLS, cols);
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_RING_LINES, ring);
  endtask

  // Mostly well-formed text with scrolls, reads and dirty clears mixed in
  task automatic test_random_traffic(int count);
    int pick, kind;
    logic [2:0] op;
    logic [7:0] ch;
    logic [4:0] r;
    logic [6:0] c;
    for (int n = 0; n < count; n++) begin
      gaps_off = (n >= count / 3) && (n < count / 2);
      pick = $urandom_range(999);
      if (pick < 550) op = OP_PUT;
      else if (pick < 630) op = OP_SCROLL_UP;
      else if (pick < 690) op = OP_SCROLL_DN;
      else if (pick < 900) op = OP_READ;
      else if (pick < 996) op = OP_CLR_DIRTY;
      else op = 3'($urandom_range(OP_REINIT_5, OP_REINIT_7));
      kind = $urandom_range(99);
      if (kind < 60) ch = 8'($urandom_range(CH_FIRST, CH_LAST));
      else if (kind < 72) ch = CH_LF;
      else if (kind < 77) ch = CH_CR;
      else if (kind < 82) ch = CH_BS;
      else if (kind < 88) ch = CH_TAB;
      else ch = 8'($urandom_range(255));
      r = ($urandom_range(99) < 70) ? 5'($urandom_range(act_rows - 1)) : 5'($urandom_range(31));
      c = ($urandom_range(99) < 70) ? 7'($urandom_range(act_cols - 1)) : 7'($urandom_range(127));
      send_cmd(op, ch, r, c);
    end
    gaps_off = 1'b0;
  endtask

  // Field extremes, every opcode and the named corner cases at reset geometry
  task automatic test_directed_edges();
    send_cmd(OP_READ, 8'h00, 5'd31, 7'd127);
    send_cmd(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_cmd(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_cmd(OP_PUT, 8'h80, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_LAST, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_FIRST, 5'd0, 7'd1);
    send_cmd(OP_PUT, 8'h41, 5'd0, 7'd2);
    send_cmd(OP_PUT, CH_TAB, 5'd0, 7'd3);
    send_cmd(OP_PUT, CH_BS, 5'd0, 7'd7);
    send_cmd(OP_PUT, CH_CR, 5'd0, 7'd0);
    send_cmd(OP_PUT, CH_LF, 5'd1, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd79);
    send_cmd(OP_READ, 8'h00, 5'd0, 7'd80);
    send_cmd(OP_READ, 8'h00, 5'd24, 7'd0);
    send_cmd(OP_SCROLL_UP, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_SCROLL_DN, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_CLR_DIRTY, 8'h00, 5'd31, 7'd0);
    send_cmd(OP_CLR_DIRTY, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_CLR_DIRTY, 8'h00, 5'd1, 7'd0);
    send_cmd(OP_REINIT_5, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_PUT, 8'h5A, 5'd0, 7'd0);
    send_cmd(OP_REINIT_6, 8'h00, 5'd0, 7'd0);
    send_cmd(OP_REINIT_7, 8'hFF, 5'd31, 7'd127);
  endtask

  // Ring smaller than the screen, then a ring that wraps, narrow lines for auto-wrap
  task automatic test_small_ring();
    set_geometry(8, 6, 4);
    test_random_traffic(150);
    set_geometry(5, 3, 7);
    test_random_traffic(150);
  endtask

  task automatic test_unit_geometry();
    set_geometry(0, 0, 0);
    test_random_traffic(80);
  endtask

  task automatic test_max_geometry();
    set_geometry(255, 63, 511);
    write_reg(REG_SPARE, 32'h0000_0011);
    test_random_traffic(200);
  endtask

  initial begin
    term_init();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_traffic(250);
    test_small_ring();
    test_unit_geometry();
    test_max_geometry();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
design/tsce_pkg.sv
design/terminal_scrollback_char_engine.sv
tb/sv/tb_top.sv
